// ===== rtl/core/wmms_pkg.sv =====
`timescale 1ns / 1ps

package wmms_pkg;

    // Window length after reset
    localparam int LEN_AT_RESET = 50;

    // Controller states
    typedef enum logic [1:0] {
        ST_ACCUM = 2'd0,   // taking samples
        ST_DIV   = 2'd1,   // mean divider running
        ST_FIN   = 2'd2    // quotient ready, waiting for the output register
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic div_step;    // one divider iteration
        logic out_load;    // move finished window into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic close;       // the current sample completes the window
        logic div_last;    // final divider iteration this cycle
    } t_sts;

endpackage

// ===== rtl/core/wmms_ctrl.sv =====
`timescale 1ns / 1ps

module wmms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  wmms_pkg::t_sts i_sts,
    output logic          o_stall,
    output logic          o_valid,
    output wmms_pkg::t_cmd o_cmd
);
    import wmms_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // Output register can take a new beat when empty or being drained
    assign out_free = !r_out_valid || !i_stall;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_ACCUM: begin
                o_cmd.accept = i_valid;
                if (i_valid && i_sts.close) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    // Output beat bookkeeping
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != ST_ACCUM);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/wmms_dpath.sv =====
`timescale 1ns / 1ps

module wmms_dpath #(
    parameter int SAMPLE_WIDTH = 10,
    parameter int COUNT_WIDTH  = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [COUNT_WIDTH-1:0]  i_cfg_wdata,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wmms_pkg::t_cmd          i_cmd,
    output wmms_pkg::t_sts          o_sts,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    output logic [SAMPLE_WIDTH-1:0] o_window_min,
    output logic [SAMPLE_WIDTH-1:0] o_peak_to_peak,
    output logic [SAMPLE_WIDTH-1:0] o_window_mean
);
    import wmms_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int SUM_W  = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    // Configuration and running window state
    logic [CW-1:0]     r_len;
    logic [SW-1:0]     r_run_max;
    logic [SW-1:0]     r_run_min;
    logic [SUM_W-1:0]  r_run_sum;
    logic [CW-1:0]     r_seen;

    // Closed window held for the divider
    logic [SW-1:0]     r_hold_max;
    logic [SW-1:0]     r_hold_min;
    logic [SUM_W-1:0]  r_dvd;       // dividend shifts out, quotient shifts in
    logic [CW-1:0]     r_dvs;
    logic [CW-1:0]     r_rem;
    logic [STEP_W-1:0] r_step;

    // Output register
    logic [SW-1:0]     r_out_max;
    logic [SW-1:0]     r_out_min;
    logic [SW-1:0]     r_out_p2p;
    logic [SW-1:0]     r_out_mean;

    logic [SW-1:0]     n_max;
    logic [SW-1:0]     n_min;
    logic [SUM_W-1:0]  n_sum;
    logic [CW-1:0]     n_cnt;
    logic [CW:0]       rem_sh;
    logic              q_bit;

    // Window update for the incoming sample
    assign n_max = (i_sample > r_run_max) ? i_sample : r_run_max;
    assign n_min = (i_sample < r_run_min) ? i_sample : r_run_min;
    assign n_sum = r_run_sum + SUM_W'(i_sample);
    assign n_cnt = r_seen + CW'(1);

    // A length of zero behaves as one: the count is never below one
    assign o_sts.close    = (n_cnt >= r_len);
    assign o_sts.div_last = (r_step == LAST_STEP);

    // Restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dvs});

    // Window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CW'(LEN_AT_RESET);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    // Running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
            r_run_min <= '1;
            r_run_sum <= '0;
            r_seen    <= '0;
        end else if (i_cmd.accept) begin
            if (o_sts.close) begin
                r_run_max <= '0;
                r_run_min <= '1;
                r_run_sum <= '0;
                r_seen    <= '0;
            end else begin
                r_run_max <= n_max;
                r_run_min <= n_min;
                r_run_sum <= n_sum;
                r_seen    <= n_cnt;
            end
        end
    end

    // Divider step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.accept && o_sts.close) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Capture closed window, then iterate the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.close) begin
            r_hold_max <= n_max;
            r_hold_min <= n_min;
            r_dvd      <= n_sum;
            r_dvs      <= n_cnt;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? CW'(rem_sh - {1'b0, r_dvs}) : rem_sh[CW-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_max  <= r_hold_max;
            r_out_min  <= r_hold_min;
            r_out_p2p  <= r_hold_max - r_hold_min;
            r_out_mean <= r_dvd[SW-1:0];
        end
    end

    assign o_window_max   = r_out_max;
    assign o_window_min   = r_out_min;
    assign o_peak_to_peak = r_out_p2p;
    assign o_window_mean  = r_out_mean;

endmodule

// ===== rtl/core/window_min_max_mean_stats_core.sv =====
`timescale 1ns / 1ps
// Windowed min / max / peak-to-peak / mean of unsigned converter samples.
//
// Input channel: i_valid / o_stall with i_sample. A beat moves on a rising
// edge with i_valid high and o_stall low. Samples are taken one per cycle
// while a window fills.
// Output channel: o_valid / i_stall with max, min, peak-to-peak and mean.
// One beat per window, sent once the window's mean is ready.
// The closing sample starts a restoring divider that produces one
// quotient bit per cycle; the result then enters the output register
// once that register is free, and o_valid rises. o_stall is
// high from the closing beat's edge until the result is loaded.
// Input is held off while a window's mean is computed and loaded;
// samples are taken one per cycle otherwise.
// A stalled result waits in the output register while the next window
// fills; a further result waits in the divider and holds off input.
// Reset (i_rst_n low, synchronous) sets the window length to 50, clears the
// running statistics and drops o_valid. i_cfg_we writes the window length;
// zero acts as one.

module window_min_max_mean_stats_core #(
    parameter int SAMPLE_WIDTH = 10,
    parameter int COUNT_WIDTH  = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [COUNT_WIDTH-1:0]  i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    output logic [SAMPLE_WIDTH-1:0] o_window_min,
    output logic [SAMPLE_WIDTH-1:0] o_peak_to_peak,
    output logic [SAMPLE_WIDTH-1:0] o_window_mean
);
    import wmms_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wmms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    wmms_dpath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_window_max   (o_window_max),
        .o_window_min   (o_window_min),
        .o_peak_to_peak (o_peak_to_peak),
        .o_window_mean  (o_window_mean)
    );

endmodule

// ===== rtl/core/wmms_chk.sv =====
`timescale 1ns / 1ps

module wmms_chk #(
    parameter int SAMPLE_WIDTH = 10
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [SAMPLE_WIDTH-1:0] o_window_max,
    input logic [SAMPLE_WIDTH-1:0] o_window_min,
    input logic [SAMPLE_WIDTH-1:0] o_peak_to_peak,
    input logic [SAMPLE_WIDTH-1:0] o_window_mean
);

    // Reset empties the output register
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_window_max)
            && $stable(o_window_min) && $stable(o_window_mean))
        else $error("stalled result changed");

    // Every window holds at least one sample, so min never exceeds max
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_min <= o_window_max)
            && (o_peak_to_peak == SAMPLE_WIDTH'(o_window_max - o_window_min)))
        else $error("min/max/peak-to-peak inconsistent");

    // Mean lies between min and max
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_mean >= o_window_min) && (o_window_mean <= o_window_max))
        else $error("mean outside window range");

endmodule

bind window_min_max_mean_stats_core wmms_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_wmms_chk (.*);
